// ----- rtl/vrow_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Voxel ray walker package
// Shared types and fixed constants of the voxel ray occlusion walker.
// ----------------------------------------------------------------------------
package vrow_pkg;

   localparam int COORD_W       = 32;
   localparam int VOX_W         = 24;
   localparam int DELTA_W       = 33;
   localparam int TIME_INT_BITS = 10;
   localparam int AXES          = 3;
   localparam int AXIS_W        = 2;

   localparam logic FUNC_START  = 1'b0;
   localparam logic FUNC_ANSWER = 1'b1;

   typedef logic [AXIS_W-1:0] axis_type;

   typedef enum logic [1:0] {
      STATUS_QUERY   = 2'd0,
      STATUS_CLEAR   = 2'd1,
      STATUS_BLOCKED = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_SQUARE,
      ST_CHECK,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_MUL,
      ST_SAT,
      ST_PICK,
      ST_STEP,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

// ----- rtl/vrow_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Voxel ray walker divider
// Restoring unsigned divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vrow_div #(
   parameter int DIVIDEND_W = 33,
   parameter int DIVISOR_W  = 33
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       done,
   output logic [DIVIDEND_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [CNT_W-1:0]      count_ff;
   logic                  done_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  den_ff;
   logic [DIVIDEND_W-1:0] num_ff;
   logic [DIVIDEND_W-1:0] quot_ff;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;
   logic [DIVISOR_W:0]    rem_in;

   assign trial  = {rem_ff, num_ff[DIVIDEND_W-1]};
   assign fits   = trial >= {1'b0, den_ff};
   assign rem_in = fits ? trial - {1'b0, den_ff} : trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else if (start) begin
         count_ff <= CNT_W'(DIVIDEND_W);
         done_ff  <= 1'b0;
      end else if (count_ff != '0) begin
         count_ff <= count_ff - CNT_W'(1);
         done_ff  <= count_ff == CNT_W'(1);
      end else begin
         done_ff  <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         den_ff  <= divisor;
         num_ff  <= dividend;
         quot_ff <= '0;
      end else if (count_ff != '0) begin
         rem_ff  <= rem_in[DIVISOR_W-1:0];
         num_ff  <= {num_ff[DIVIDEND_W-2:0], 1'b0};
         quot_ff <= {quot_ff[DIVIDEND_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule
`default_nettype wire

// ----- rtl/voxel_ray_occlusion_walker_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Voxel ray occlusion walker
// Walks unit voxels along a segment, one voxel query per transaction.
// An answer transaction passes the pick and step states before its result,
// or goes straight to its result when no walk is live or the voxel is solid.
// A start transaction, unless it finishes at once, runs the one-bit-per-cycle
// divider shared by the three axes to find each axis's crossing interval.
// One transaction is in work at a time; reset clears the walk and the output.
// ----------------------------------------------------------------------------
module voxel_ray_occlusion_walker_top #(
   parameter int COORD_FRAC_BITS = 8,
   parameter int TIME_FRAC_BITS  = 24
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_func,
   input  wire logic [31:0] req_origin_x,
   input  wire logic [31:0] req_origin_y,
   input  wire logic [31:0] req_origin_z,
   input  wire logic [31:0] req_target_x,
   input  wire logic [31:0] req_target_y,
   input  wire logic [31:0] req_target_z,
   input  wire logic        req_solid,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [23:0]      rsp_voxel_x,
   output logic [23:0]      rsp_voxel_y,
   output logic [23:0]      rsp_voxel_z
);

   localparam int C       = COORD_FRAC_BITS;
   localparam int TW      = vrow_pkg::TIME_INT_BITS + TIME_FRAC_BITS;
   localparam int NUM_W   = C + TIME_FRAC_BITS + 1;
   localparam int QX_W    = (NUM_W > TW) ? NUM_W : TW;
   localparam int FRAC_W  = C + 1;
   localparam int PROD_W  = FRAC_W + TW;
   localparam int SQ_W    = 2 * C + 2;
   localparam int CW      = vrow_pkg::COORD_W;
   localparam int VW      = vrow_pkg::VOX_W;
   localparam int DW      = vrow_pkg::DELTA_W;
   localparam longint unsigned SQ_LIMIT_L = ((64'd1 << (2 * C)) - 64'd1) / 64'd10000;
   localparam logic [SQ_W-1:0]   SQ_LIMIT = SQ_W'(SQ_LIMIT_L);
   localparam logic [TW-1:0]     T_ONES   = '1;
   localparam logic [TW-1:0]     T_ONE    =
      {{(TW - TIME_FRAC_BITS - 1){1'b0}}, 1'b1, {TIME_FRAC_BITS{1'b0}}};
   localparam logic [NUM_W-1:0]  DIV_NUM  = {1'b1, {(NUM_W - 1){1'b0}}};
   localparam logic [FRAC_W-1:0] FRAC_ONE = {1'b1, {C{1'b0}}};

   vrow_pkg::state_type  state_ff, state_in;
   vrow_pkg::axis_type   axis_ff;
   vrow_pkg::axis_type   pick_axis;
   vrow_pkg::status_type res_status_ff;
   logic                 active_ff;

   logic [CW-1:0]           o_ff    [vrow_pkg::AXES];
   logic [CW-1:0]           t_ff    [vrow_pkg::AXES];
   logic [DW-1:0]           ad_ff   [vrow_pkg::AXES];
   logic signed [1:0]       step_ff [vrow_pkg::AXES];
   logic [VW-1:0]           cur_ff  [vrow_pkg::AXES];
   logic [VW-1:0]           end_ff  [vrow_pkg::AXES];
   logic [2*C-1:0]          sqp_ff  [vrow_pkg::AXES];
   logic [TW-1:0]           ival_ff [vrow_pkg::AXES];
   logic [TW-1:0]           next_ff [vrow_pkg::AXES];
   logic                    small_ff;
   logic [PROD_W-1:0]       prod_ff;

   logic                    rsp_valid_ff;
   logic [1:0]              rsp_status_ff;
   logic [VW-1:0]           rsp_vx_ff, rsp_vy_ff, rsp_vz_ff;

   logic                    req_take;
   logic                    slot_free;
   logic                    div_start;
   logic                    div_done;
   logic [NUM_W-1:0]        div_quot;
   logic [SQ_W-1:0]         sq_sum;
   logic                    same_voxel;
   logic                    step_zero;
   logic [QX_W-1:0]         q_ext;
   logic [TW-1:0]           q_sat;
   logic [C-1:0]            low_bits;
   logic [FRAC_W-1:0]       frac;
   logic [TW:0]             m_val;
   logic [VW-1:0]           vox_step;
   logic                    hit_end;
   logic [TW:0]             t_sum;
   logic [TW-1:0]           t_add;
   logic signed [CW:0]      delta   [vrow_pkg::AXES];
   logic [CW-1:0]           o_shift [vrow_pkg::AXES];
   logic [CW-1:0]           t_shift [vrow_pkg::AXES];

   vrow_div #(
      .DIVIDEND_W (NUM_W),
      .DIVISOR_W  (DW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (DIV_NUM),
      .divisor  (ad_ff[axis_ff]),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign req_take  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      for (int i = 0; i < vrow_pkg::AXES; i++) begin
         delta[i]   = $signed({t_ff[i][CW-1], t_ff[i]}) - $signed({o_ff[i][CW-1], o_ff[i]});
         o_shift[i] = CW'($signed(o_ff[i]) >>> C);
         t_shift[i] = CW'($signed(t_ff[i]) >>> C);
      end
   end

   assign sq_sum     = SQ_W'(sqp_ff[0]) + SQ_W'(sqp_ff[1]) + SQ_W'(sqp_ff[2]);
   assign same_voxel = (cur_ff[0] == end_ff[0]) && (cur_ff[1] == end_ff[1]) &&
                       (cur_ff[2] == end_ff[2]);
   assign step_zero  = step_ff[axis_ff] == 2'sb00;

   always_comb begin
      q_ext = QX_W'(div_quot);
      if (q_ext > QX_W'(T_ONES)) begin
         q_sat = T_ONES;
      end else if (q_ext == '0) begin
         q_sat = TW'(1);
      end else begin
         q_sat = TW'(q_ext);
      end
   end

   assign low_bits = o_ff[axis_ff][C-1:0];
   assign frac     = (step_ff[axis_ff] == 2'sb01) ? FRAC_ONE - {1'b0, low_bits}
                                                  : {1'b0, low_bits};
   assign m_val    = prod_ff[PROD_W-1:C];

   always_comb begin
      if (next_ff[0] < next_ff[1] && next_ff[0] < next_ff[2]) begin
         pick_axis = vrow_pkg::axis_type'(0);
      end else if (next_ff[1] < next_ff[2]) begin
         pick_axis = vrow_pkg::axis_type'(1);
      end else begin
         pick_axis = vrow_pkg::axis_type'(2);
      end
   end

   assign vox_step = cur_ff[axis_ff] + VW'(step_ff[axis_ff]);
   assign t_sum    = {1'b0, next_ff[axis_ff]} + {1'b0, ival_ff[axis_ff]};
   assign t_add    = t_sum[TW] ? T_ONES : t_sum[TW-1:0];

   always_comb begin
      hit_end = 1'b1;
      for (int i = 0; i < vrow_pkg::AXES; i++) begin
         if (vrow_pkg::axis_type'(i) == axis_ff) begin
            hit_end = hit_end && (vox_step == end_ff[i]);
         end else begin
            hit_end = hit_end && (cur_ff[i] == end_ff[i]);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vrow_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_func == vrow_pkg::FUNC_START) begin
                  state_in = vrow_pkg::ST_SETUP;
               end else if (!active_ff || req_solid) begin
                  state_in = vrow_pkg::ST_EMIT;
               end else begin
                  state_in = vrow_pkg::ST_PICK;
               end
            end
         end
         vrow_pkg::ST_SETUP:  state_in = vrow_pkg::ST_SQUARE;
         vrow_pkg::ST_SQUARE: state_in = vrow_pkg::ST_CHECK;
         vrow_pkg::ST_CHECK: begin
            if ((small_ff && sq_sum <= SQ_LIMIT) || same_voxel) begin
               state_in = vrow_pkg::ST_EMIT;
            end else begin
               state_in = vrow_pkg::ST_DIV_START;
            end
         end
         vrow_pkg::ST_DIV_START: begin
            if (!step_zero) begin
               state_in = vrow_pkg::ST_DIV_WAIT;
            end else if (axis_ff == vrow_pkg::axis_type'(2)) begin
               state_in = vrow_pkg::ST_PICK;
            end
         end
         vrow_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = vrow_pkg::ST_MUL;
            end
         end
         vrow_pkg::ST_MUL: state_in = vrow_pkg::ST_SAT;
         vrow_pkg::ST_SAT: begin
            if (axis_ff == vrow_pkg::axis_type'(2)) begin
               state_in = vrow_pkg::ST_PICK;
            end else begin
               state_in = vrow_pkg::ST_DIV_START;
            end
         end
         vrow_pkg::ST_PICK: state_in = vrow_pkg::ST_STEP;
         vrow_pkg::ST_STEP: state_in = vrow_pkg::ST_EMIT;
         vrow_pkg::ST_EMIT: begin
            if (slot_free) begin
               state_in = vrow_pkg::ST_IDLE;
            end
         end
         default: state_in = vrow_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = state_ff != vrow_pkg::ST_IDLE;
      div_start = (state_ff == vrow_pkg::ST_DIV_START) && !step_zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vrow_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         case (state_ff)
            vrow_pkg::ST_IDLE: begin
               if (req_take && (req_func == vrow_pkg::FUNC_START || req_solid)) begin
                  active_ff <= 1'b0;
               end
            end
            vrow_pkg::ST_STEP: begin
               active_ff <= !(next_ff[axis_ff] > T_ONE) && !hit_end;
            end
            default: active_ff <= active_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         vrow_pkg::ST_IDLE: begin
            if (req_take) begin
               o_ff[0] <= req_origin_x;
               o_ff[1] <= req_origin_y;
               o_ff[2] <= req_origin_z;
               t_ff[0] <= req_target_x;
               t_ff[1] <= req_target_y;
               t_ff[2] <= req_target_z;
               if (req_func == vrow_pkg::FUNC_ANSWER && !active_ff) begin
                  res_status_ff <= vrow_pkg::STATUS_CLEAR;
               end else begin
                  res_status_ff <= vrow_pkg::STATUS_BLOCKED;
               end
            end
         end
         vrow_pkg::ST_SETUP: begin
            for (int i = 0; i < vrow_pkg::AXES; i++) begin
               ad_ff[i]   <= delta[i][CW] ? DW'(-delta[i]) : DW'(delta[i]);
               step_ff[i] <= delta[i][CW] ? -2'sd1 : ((delta[i] != '0) ? 2'sd1 : 2'sd0);
               cur_ff[i]  <= o_shift[i][VW-1:0];
               end_ff[i]  <= t_shift[i][VW-1:0];
            end
         end
         vrow_pkg::ST_SQUARE: begin
            small_ff <= (ad_ff[0][DW-1:C] == '0) && (ad_ff[1][DW-1:C] == '0) &&
                        (ad_ff[2][DW-1:C] == '0);
            for (int i = 0; i < vrow_pkg::AXES; i++) begin
               sqp_ff[i] <= ad_ff[i][C-1:0] * ad_ff[i][C-1:0];
            end
         end
         vrow_pkg::ST_CHECK: begin
            axis_ff       <= vrow_pkg::axis_type'(0);
            res_status_ff <= vrow_pkg::STATUS_CLEAR;
         end
         vrow_pkg::ST_DIV_START: begin
            if (step_zero) begin
               ival_ff[axis_ff] <= T_ONES;
               next_ff[axis_ff] <= T_ONES;
               if (axis_ff != vrow_pkg::axis_type'(2)) begin
                  axis_ff <= axis_ff + vrow_pkg::axis_type'(1);
               end
            end
         end
         vrow_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               ival_ff[axis_ff] <= q_sat;
            end
         end
         vrow_pkg::ST_MUL: begin
            prod_ff <= frac * ival_ff[axis_ff];
         end
         vrow_pkg::ST_SAT: begin
            next_ff[axis_ff] <= (m_val > {1'b0, T_ONES}) ? T_ONES : m_val[TW-1:0];
            if (axis_ff != vrow_pkg::axis_type'(2)) begin
               axis_ff <= axis_ff + vrow_pkg::axis_type'(1);
            end
         end
         vrow_pkg::ST_PICK: begin
            axis_ff <= pick_axis;
         end
         vrow_pkg::ST_STEP: begin
            cur_ff[axis_ff] <= vox_step;
            if (next_ff[axis_ff] > T_ONE) begin
               res_status_ff <= vrow_pkg::STATUS_CLEAR;
            end else begin
               next_ff[axis_ff] <= t_add;
               res_status_ff    <= hit_end ? vrow_pkg::STATUS_CLEAR : vrow_pkg::STATUS_QUERY;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == vrow_pkg::ST_EMIT && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == vrow_pkg::ST_EMIT && slot_free) begin
         rsp_status_ff <= res_status_ff;
         if (res_status_ff == vrow_pkg::STATUS_QUERY) begin
            rsp_vx_ff <= cur_ff[0];
            rsp_vy_ff <= cur_ff[1];
            rsp_vz_ff <= cur_ff[2];
         end else begin
            rsp_vx_ff <= '0;
            rsp_vy_ff <= '0;
            rsp_vz_ff <= '0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_voxel_x = rsp_vx_ff;
   assign rsp_voxel_y = rsp_vy_ff;
   assign rsp_voxel_z = rsp_vz_ff;

   a_start_drops_walk: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_func == vrow_pkg::FUNC_START) |=> !active_ff)
      else $error("A start transaction did not drop the live walk.");

   a_final_has_no_voxel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != vrow_pkg::STATUS_QUERY) |->
      (rsp_voxel_x == '0 && rsp_voxel_y == '0 && rsp_voxel_z == '0))
      else $error("A finished result carries a nonzero voxel.");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == vrow_pkg::ST_DIV_WAIT)
      else $error("The divider finished outside of a divide wait.");

   a_query_keeps_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vrow_pkg::ST_EMIT && slot_free &&
       res_status_ff == vrow_pkg::STATUS_QUERY) |-> active_ff)
      else $error("A voxel query was issued without a live walk.");

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Voxel ray occlusion walker testbench
// Drives start and answer transactions into the walker, predicts every
// status and voxel query from an internal model of the grid traversal, and
// compares each result in order. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

   localparam int              COORD_FRAC = 8;
   localparam int              TIME_FRAC  = 24;
   localparam int              ITEM_GOAL  = 1050;
   localparam int              QUIET_MAX  = 4000;
   localparam int              END_WAIT   = 200;
   localparam longint unsigned T_ONES     =
      (64'd1 << (TIME_FRAC + vrow_pkg::TIME_INT_BITS)) - 1;
   localparam longint unsigned T_ONE      = 64'd1 << TIME_FRAC;

   typedef struct {
      logic             func;
      logic [2:0][31:0] origin;
      logic [2:0][31:0] target;
      logic             solid;
      bit               drain;
   } ray_item_type;

   typedef struct {
      vrow_pkg::status_type status;
      logic [2:0][23:0]     voxel;
   } walk_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_func = vrow_pkg::FUNC_ANSWER;
   logic [31:0] req_origin_x = '0;
   logic [31:0] req_origin_y = '0;
   logic [31:0] req_origin_z = '0;
   logic [31:0] req_target_x = '0;
   logic [31:0] req_target_y = '0;
   logic [31:0] req_target_z = '0;
   logic        req_solid = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [23:0] rsp_voxel_x;
   logic [23:0] rsp_voxel_y;
   logic [23:0] rsp_voxel_z;

   ray_item_type    pending_items[$];
   walk_result_type expected_results[$];
   int              item_total = 0;
   int              items_sent = 0;
   int              accepted_count = 0;
   int              results_seen = 0;
   int              fail_count = 0;
   int              quiet_cycles = 0;
   int              send_idle = 0;
   int              rsp_hold = 0;
   bit              long_hold_done = 1'b0;
   logic            req_took = 1'b0;

   // Walk state of the traversal model.
   logic             walk_live = 1'b0;
   logic [2:0][23:0] walk_voxel;
   logic [2:0][23:0] goal_voxel;
   logic [2:0][33:0] cross_time;
   logic [2:0][33:0] cross_step;
   int               step_dir[3];

   voxel_ray_occlusion_walker_top DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_origin_x (req_origin_x),
      .req_origin_y (req_origin_y),
      .req_origin_z (req_origin_z),
      .req_target_x (req_target_x),
      .req_target_y (req_target_y),
      .req_target_z (req_target_z),
      .req_solid    (req_solid),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_voxel_x  (rsp_voxel_x),
      .rsp_voxel_y  (rsp_voxel_y),
      .rsp_voxel_z  (rsp_voxel_z)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic walk_result_type advance_walk();
      int              a;
      logic [34:0]     sum;
      walk_result_type r;
      r.status = vrow_pkg::STATUS_CLEAR;
      r.voxel  = '0;
      if (cross_time[0] < cross_time[1] && cross_time[0] < cross_time[2]) a = 0;
      else if (cross_time[1] < cross_time[2]) a = 1;
      else a = 2;
      walk_voxel[a] = walk_voxel[a] + 24'(step_dir[a]);
      if (cross_time[a] > T_ONE) begin
         walk_live = 1'b0;
         return r;
      end
      sum = {1'b0, cross_time[a]} + {1'b0, cross_step[a]};
      cross_time[a] = (sum > T_ONES) ? T_ONES[33:0] : sum[33:0];
      if (walk_voxel == goal_voxel) begin
         walk_live = 1'b0;
         return r;
      end
      walk_live = 1'b1;
      r.status  = vrow_pkg::STATUS_QUERY;
      r.voxel   = walk_voxel;
      return r;
   endfunction

   function automatic walk_result_type start_walk(ray_item_type it);
      longint          o[3];
      longint          t[3];
      longint          d;
      longint unsigned ad[3];
      longint unsigned sq, q, low, frac, m;
      bit              all_short;
      int              i;
      walk_result_type r;
      r.status  = vrow_pkg::STATUS_CLEAR;
      r.voxel   = '0;
      walk_live = 1'b0;
      all_short = 1'b1;
      for (i = 0; i < 3; i++) begin
         o[i] = longint'($signed(it.origin[i]));
         t[i] = longint'($signed(it.target[i]));
         d = t[i] - o[i];
         ad[i] = (d < 0) ? longint'(-d) : d;
         if (ad[i] > 255) all_short = 1'b0;
         step_dir[i] = (d > 0) ? 1 : ((d < 0) ? -1 : 0);
      end
      if (all_short) begin
         sq = ad[0] * ad[0] + ad[1] * ad[1] + ad[2] * ad[2];
         if (sq * 10000 < (64'd1 << (2 * COORD_FRAC))) return r;
      end
      for (i = 0; i < 3; i++) begin
         walk_voxel[i] = 24'($signed(it.origin[i]) >>> COORD_FRAC);
         goal_voxel[i] = 24'($signed(it.target[i]) >>> COORD_FRAC);
      end
      if (walk_voxel == goal_voxel) return r;
      for (i = 0; i < 3; i++) begin
         if (step_dir[i] == 0) begin
            cross_step[i] = T_ONES[33:0];
            cross_time[i] = T_ONES[33:0];
         end else begin
            q    = (64'd1 << (COORD_FRAC + TIME_FRAC)) / ad[i];
            low  = longint'(o[i]) & 64'hFF;
            frac = (step_dir[i] > 0) ? (64'd256 - low) : low;
            if (q > T_ONES) q = T_ONES;
            if (q == 0) q = 1;
            cross_step[i] = q[33:0];
            m = (frac * q) >> COORD_FRAC;
            cross_time[i] = (m > T_ONES) ? T_ONES[33:0] : m[33:0];
         end
      end
      return advance_walk();
   endfunction

   function automatic walk_result_type predict_result(ray_item_type it);
      walk_result_type r;
      r.status = vrow_pkg::STATUS_CLEAR;
      r.voxel  = '0;
      if (it.func == vrow_pkg::FUNC_START) r = start_walk(it);
      else if (walk_live && it.solid) begin
         walk_live = 1'b0;
         r.status  = vrow_pkg::STATUS_BLOCKED;
      end else if (walk_live) r = advance_walk();
      return r;
   endfunction

   function automatic logic [2:0][31:0] xyz(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      return {z, y, x};
   endfunction

   function automatic void push_start(logic [2:0][31:0] o, logic [2:0][31:0] t, bit drain);
      ray_item_type it;
      it.func   = vrow_pkg::FUNC_START;
      it.origin = o;
      it.target = t;
      it.solid  = 1'($urandom);
      it.drain  = drain;
      pending_items.insert(pending_items.size(), it);
   endfunction

   function automatic void push_answer(bit solid);
      ray_item_type it;
      it.func   = vrow_pkg::FUNC_ANSWER;
      it.origin = xyz($urandom, $urandom, $urandom);
      it.target = xyz($urandom, $urandom, $urandom);
      it.solid  = solid;
      it.drain  = 1'b0;
      pending_items.insert(pending_items.size(), it);
   endfunction

   // A start near a random point with a short segment, then answers that
   // mostly follow the walk to its end and sometimes hit a solid voxel.
   function automatic void add_walk_sequence(bit drain);
      logic [2:0][31:0] o, t;
      int               span, delta, dv, steps, count, block_at, i, k;
      span  = $urandom_range(1, 6);
      steps = 0;
      for (i = 0; i < 3; i++) begin
         o[i] = $urandom;
         case ($urandom_range(0, 9))
            0:       delta = 0;
            1:       delta = $urandom_range(0, 4) - 2;
            default: delta = $urandom_range(0, 2 * span * 256) - span * 256;
         endcase
         t[i] = o[i] + 32'(delta);
         dv = ($signed(t[i]) >>> COORD_FRAC) - ($signed(o[i]) >>> COORD_FRAC);
         steps += (dv < 0) ? -dv : dv;
      end
      if (steps > 40 || steps < 0) steps = 40;
      count = steps + $urandom_range(0, 2);
      if ($urandom_range(0, 9) == 0) count = $urandom_range(0, count);
      block_at = ($urandom_range(0, 99) < 35) ? $urandom_range(0, count) : -1;
      push_start(o, t, drain);
      for (k = 0; k < count; k++) push_answer(k == block_at);
   endfunction

   function automatic void add_noise_sequence();
      int n, k;
      n = $urandom_range(0, 4);
      if ($urandom_range(0, 1) == 0)
         push_start(xyz($urandom, $urandom, $urandom), xyz($urandom, $urandom, $urandom), 1'b0);
      for (k = 0; k < n; k++) push_answer(1'($urandom));
   endfunction

   function automatic bit idle_phase(int n);
      return (n < item_total - 150) && ((n / 100) % 3 != 2);
   endfunction

   task automatic check_field(string name, logic [23:0] want, logic [23:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   initial begin
      int seq;
      seq = 0;
      push_answer(1'b0);
      push_answer(1'b1);
      push_start(xyz(32'h0, 32'h0, 32'h0), xyz(32'h1, 32'h1, 32'h1), 1'b0);
      push_start(xyz(32'h0, 32'h0, 32'h0), xyz(32'h2, 32'h2, 32'h1), 1'b0);
      push_start(xyz(32'h10, 32'h20, 32'h30), xyz(32'hF0, 32'h80, 32'h10), 1'b0);
      push_start(xyz(32'h80, 32'h80, 32'h80), xyz(32'h380, 32'h80, 32'h80), 1'b0);
      push_answer(1'b0);
      push_answer(1'b0);
      push_answer(1'b0);
      push_start(xyz(32'h280, 32'hFFFFFE80, 32'h40), xyz(32'hFFFFFF00, 32'h100, 32'h300),
                 1'b0);
      push_answer(1'b0);
      push_answer(1'b1);
      push_answer(1'b0);
      push_start(xyz(32'h300, 32'h100, 32'h100), xyz(32'h100, 32'h100, 32'h100), 1'b0);
      push_answer(1'b0);
      push_answer(1'b0);
      push_start(xyz(32'h0, 32'h0, 32'h0), xyz(32'h1000, 32'h800, 32'h400), 1'b0);
      push_answer(1'b0);
      push_start(xyz(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF),
                 xyz(32'h80000000, 32'h7FFFFFFF, 32'h00000000), 1'b0);
      push_answer(1'b0);
      push_answer(1'b0);
      push_start(xyz(32'h80000000, 32'h80000000, 32'h80000000),
                 xyz(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF), 1'b0);
      push_answer(1'b0);
      push_answer(1'b1);
      while (pending_items.size() < ITEM_GOAL) begin
         seq++;
         if ($urandom_range(0, 99) < 85) add_walk_sequence(seq % 40 == 0);
         else add_noise_sequence();
      end
      item_total = pending_items.size();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (accepted_count < item_total) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (END_WAIT) @(posedge clock);
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Sender: a new transaction only once the previous one has been taken.
   always @(negedge clock) begin
      ray_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (send_idle > 0) begin
            send_idle--;
            req_valid <= 1'b0;
         end else if (pending_items.size() == 0 ||
                      (pending_items[0].drain && expected_results.size() != 0)) begin
            req_valid <= 1'b0;
         end else if (idle_phase(items_sent) && $urandom_range(0, 15) == 0) begin
            send_idle = $urandom_range(0, 7);
            req_valid <= 1'b0;
         end else begin
            it = pending_items.pop_front();
            req_func     <= it.func;
            req_origin_x <= it.origin[0];
            req_origin_y <= it.origin[1];
            req_origin_z <= it.origin[2];
            req_target_x <= it.target[0];
            req_target_y <= it.target[1];
            req_target_z <= it.target[2];
            req_solid    <= it.solid;
            req_valid    <= 1'b1;
            items_sent++;
         end
      end
   end

   // Receiver: random stall bursts and one long hold-off that backs up the walker.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_stall <= 1'b1;
      end else if (!long_hold_done && results_seen >= 300) begin
         long_hold_done = 1'b1;
         rsp_hold = 400;
         rsp_stall <= 1'b1;
      end else if (idle_phase(results_seen) && $urandom_range(0, 15) == 0) begin
         rsp_hold = $urandom_range(0, 7);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      ray_item_type    it;
      walk_result_type want;
      if (reset) begin
         req_took <= 1'b0;
         walk_live = 1'b0;
         quiet_cycles = 0;
      end else begin
         req_took <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               $error("result with no transaction pending: status %0d", rsp_status);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("status", 24'(want.status), 24'(rsp_status));
               check_field("voxel_x", want.voxel[0], rsp_voxel_x);
               check_field("voxel_y", want.voxel[1], rsp_voxel_y);
               check_field("voxel_z", want.voxel[2], rsp_voxel_z);
            end
         end
         if (req_valid && !req_stall) begin
            it.func   = req_func;
            it.origin = xyz(req_origin_x, req_origin_y, req_origin_z);
            it.target = xyz(req_target_x, req_target_y, req_target_z);
            it.solid  = req_solid;
            it.drain  = 1'b0;
            expected_results.insert(expected_results.size(), predict_result(it));
            accepted_count++;
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_MAX) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

endmodule
